// ===== design/sapp_pkg.sv =====
package sapp_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ANGLE_FRAC_BITS_DEF = 7;
	localparam int TABLE_LEN = 24;
	localparam int CW = 36;
	localparam int ZW = 26;
	localparam int SQW = 34;
	localparam logic signed [CW-1:0] INV_GAIN_Q30 = CW'(652032874);

	localparam logic [1:0] REG_HOUR = 2'd0;
	localparam logic [1:0] REG_MINUTE = 2'd1;
	localparam logic [1:0] REG_SECOND = 2'd2;
	localparam logic [1:0] REG_DECL = 2'd3;

	function automatic logic signed [ZW-1:0] atan_entry(input int i);
		logic signed [ZW-1:0] r;
		begin
			case (i)
				0: r = ZW'(2949120);
				1: r = ZW'(1740967);
				2: r = ZW'(919879);
				3: r = ZW'(466945);
				4: r = ZW'(234379);
				5: r = ZW'(117304);
				6: r = ZW'(58666);
				7: r = ZW'(29335);
				8: r = ZW'(14668);
				9: r = ZW'(7334);
				10: r = ZW'(3667);
				11: r = ZW'(1833);
				12: r = ZW'(917);
				13: r = ZW'(458);
				14: r = ZW'(229);
				15: r = ZW'(115);
				16: r = ZW'(57);
				17: r = ZW'(29);
				18: r = ZW'(14);
				19: r = ZW'(7);
				20: r = ZW'(4);
				21: r = ZW'(2);
				22: r = ZW'(1);
				default: r = '0;
			endcase
			return r;
		end
	endfunction

endpackage

// ===== design/sapp_sincos.sv =====
module sapp_sincos #(
	parameter int CORDIC_STEPS = sapp_pkg::CORDIC_STEPS_DEF,
	parameter int ANGLE_FRAC_BITS = sapp_pkg::ANGLE_FRAC_BITS_DEF
) (
	input logic clk,
	input logic signed [sapp_pkg::ZW-1:0] angle,
	output logic signed [17:0] cos_o,
	output logic signed [17:0] sin_o
);
	import sapp_pkg::*;

	localparam int N = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
	localparam logic signed [ZW-1:0] HALF = ZW'(180 << ANGLE_FRAC_BITS);
	localparam logic signed [ZW-1:0] QTR = ZW'(90 << ANGLE_FRAC_BITS);

	logic signed [CW-1:0] x_s [0:N];
	logic signed [CW-1:0] y_s [0:N];
	logic signed [ZW-1:0] z_s [0:N];
	logic neg_s [0:N];
	logic signed [ZW-1:0] r;
	logic nr;
	logic signed [CW-1:0] xr, yr;
	logic signed [17:0] xc, yc;

	always_comb begin
		r = angle;
		nr = 1'b0;
		if (r > QTR) begin
			r = r - HALF;
			nr = 1'b1;
		end else if (r < -QTR) begin
			r = r + HALF;
			nr = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0] <= INV_GAIN_Q30;
		y_s[0] <= '0;
		z_s[0] <= r <<< (16 - ANGLE_FRAC_BITS);
		neg_s[0] <= nr;
	end

	for (genvar i = 0; i < N; i++) begin : g_it
		always_ff @(posedge clk) begin
			if (z_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - atan_entry(i);
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + atan_entry(i);
			end
			neg_s[i+1] <= neg_s[i];
		end
	end

	always_comb begin
		xr = (x_s[N] + CW'(8192)) >>> 14;
		yr = (y_s[N] + CW'(8192)) >>> 14;
		xc = (xr > CW'(65536)) ? 18'sd65536 : (xr < -CW'(65536)) ? -18'sd65536 : xr[17:0];
		yc = (yr > CW'(65536)) ? 18'sd65536 : (yr < -CW'(65536)) ? -18'sd65536 : yr[17:0];
	end

	always_ff @(posedge clk) begin
		cos_o <= neg_s[N] ? -xc : xc;
		sin_o <= neg_s[N] ? -yc : yc;
	end
endmodule

// ===== design/sapp_sqrt.sv =====
module sapp_sqrt (
	input logic clk,
	input logic [sapp_pkg::SQW-1:0] v,
	input logic signed [17:0] s_i,
	output logic [17:0] root,
	output logic signed [17:0] s_o
);
	import sapp_pkg::*;

	localparam int ST = 17;

	logic [SQW-1:0] rem_s [0:ST];
	logic [SQW-1:0] res_s [0:ST];
	logic signed [17:0] sv_s [0:ST];

	always_ff @(posedge clk) begin
		rem_s[0] <= v;
		res_s[0] <= '0;
		sv_s[0] <= s_i;
	end

	for (genvar k = 0; k < ST; k++) begin : g_sq
		localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (ST - 1 - k));
		always_ff @(posedge clk) begin
			if (rem_s[k] >= res_s[k] + BIT) begin
				rem_s[k+1] <= rem_s[k] - (res_s[k] + BIT);
				res_s[k+1] <= (res_s[k] >> 1) + BIT;
			end else begin
				rem_s[k+1] <= rem_s[k];
				res_s[k+1] <= res_s[k] >> 1;
			end
			sv_s[k+1] <= sv_s[k];
		end
	end

	assign root = res_s[ST][17:0];
	assign s_o = sv_s[ST];
endmodule

// ===== design/sapp_atan2.sv =====
module sapp_atan2 #(
	parameter int CORDIC_STEPS = sapp_pkg::CORDIC_STEPS_DEF
) (
	input logic clk,
	input logic signed [17:0] s,
	input logic [17:0] c,
	output logic signed [sapp_pkg::ZW-1:0] z
);
	import sapp_pkg::*;

	localparam int N = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

	logic signed [CW-1:0] x_s [0:N];
	logic signed [CW-1:0] y_s [0:N];
	logic signed [ZW-1:0] z_s [0:N];

	always_ff @(posedge clk) begin
		x_s[0] <= CW'($signed({1'b0, c})) <<< 14;
		y_s[0] <= CW'(s) <<< 14;
		z_s[0] <= '0;
	end

	for (genvar i = 0; i < N; i++) begin : g_it
		always_ff @(posedge clk) begin
			if (y_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + atan_entry(i);
			end else begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - atan_entry(i);
			end
		end
	end

	assign z = z_s[N];
endmodule

// ===== design/solar_altitude_per_pixel_unit.sv =====
// Solar altitude per map pixel.
// Configuration: write cfg_we with cfg_index 0..3 (hour, minute, second,
// declination) and cfg_data; writes take effect at once. The user must make writes
// only while no pixel is in flight; the block itself does not enforce this.
// Input: a pixel transfer happens at each rising edge with start high and
// busy low. Busy is always low, so one pixel may enter every cycle.
// Output: done pulses for one cycle with altitude valid; the receiver cannot
// stall, and results leave in input order.
// Pipeline: the rotation CORDIC, the 17-step square root and the vectoring
// CORDIC, each one stage per step. Throughput is one pixel per cycle.
// Reset clears the configuration registers, done and the valid bits of the
// pipeline; pixels in flight at reset are dropped.
module solar_altitude_per_pixel_unit #(
	parameter int CORDIC_STEPS = sapp_pkg::CORDIC_STEPS_DEF,
	parameter int ANGLE_FRAC_BITS = sapp_pkg::ANGLE_FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic signed [15:0] latitude,
	input logic signed [15:0] longitude,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [12:0] cfg_data,
	output logic done,
	output logic signed [14:0] altitude
);
	import sapp_pkg::*;

	localparam int N = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
	localparam int U = 1 << ANGLE_FRAC_BITS;
	localparam int LAT = N + 4;
	localparam int LAT2 = LAT + 18;
	localparam int LAT3 = LAT2 + N + 3;
	localparam int SHB = 16 - ANGLE_FRAC_BITS;
	localparam logic [47:0] SEC_RECIP = 48'd1118482;
	localparam int SEC_SHIFT = 28;

	logic [4:0] hour_q;
	logic [5:0] minute_q, second_q;
	logic signed [12:0] decl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_q <= '0;
			minute_q <= '0;
			second_q <= '0;
			decl_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HOUR: hour_q <= cfg_data[4:0];
				REG_MINUTE: minute_q <= cfg_data[5:0];
				REG_SECOND: second_q <= cfg_data[5:0];
				REG_DECL: decl_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;
	wire acc = start;

	logic signed [ZW-1:0] lat_c, lon_c, dec_c, ha_c, tm_c, ha_r, ha_w;
	logic bad_c;
	logic [47:0] sec_p;

	always_comb begin
		lat_c = ZW'(latitude);
		if (lat_c > ZW'(90 * U)) lat_c = ZW'(90 * U);
		if (lat_c < -ZW'(90 * U)) lat_c = -ZW'(90 * U);
		lon_c = ZW'(longitude);
		if (lon_c > ZW'(180 * U)) lon_c = ZW'(180 * U);
		if (lon_c < -ZW'(180 * U)) lon_c = -ZW'(180 * U);
		dec_c = ZW'(decl_q);
		if (dec_c > ZW'(24 * U)) dec_c = ZW'(24 * U);
		if (dec_c < -ZW'(24 * U)) dec_c = -ZW'(24 * U);
		sec_p = 48'(ZW'(second_q) * ZW'(U) + ZW'(120)) * SEC_RECIP;
		tm_c = ZW'(15 * U) * ZW'(hour_q) + ((ZW'(minute_q) * ZW'(U)) >>> 2)
			+ ZW'(sec_p >> SEC_SHIFT);
		ha_c = tm_c + lon_c - ZW'(180 * U);
		bad_c = (hour_q > 5'd24) || (minute_q > 6'd60) || (second_q > 6'd60);
	end

	logic signed [ZW-1:0] lat_s1, dec_s1, ha_s1;
	logic bad_s1;
	always_ff @(posedge clk) begin
		lat_s1 <= lat_c;
		dec_s1 <= dec_c;
		ha_s1 <= ha_c;
		bad_s1 <= bad_c;
	end

	// Hour angle range is within one turn of (-180,180].
	always_comb begin
		ha_r = ha_s1;
		if (ha_r > ZW'(180 * U)) ha_r = ha_r - ZW'(360 * U);
		else if (ha_r <= -ZW'(180 * U)) ha_r = ha_r + ZW'(360 * U);
		ha_w = ha_r;
	end

	logic signed [17:0] cl, sl, cd, sd, ch, sh;
	sapp_sincos #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS))
		u_lat (.clk(clk), .angle(lat_s1), .cos_o(cl), .sin_o(sl));
	sapp_sincos #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS))
		u_dec (.clk(clk), .angle(dec_s1), .cos_o(cd), .sin_o(sd));
	sapp_sincos #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS))
		u_ha (.clk(clk), .angle(ha_w), .cos_o(ch), .sin_o(sh));

	logic signed [35:0] ss_p, cc_p;
	logic signed [17:0] ch_p;
	always_ff @(posedge clk) begin
		ss_p <= 36'(sl) * 36'(sd);
		cc_p <= 36'(cl) * 36'(cd);
		ch_p <= ch;
	end

	logic signed [35:0] ss_q2, ccc_q2;
	always_ff @(posedge clk) begin
		ss_q2 <= ss_p;
		ccc_q2 <= 36'(cc_p >>> 16) * 36'(ch_p);
	end

	logic signed [36:0] t_c, tr_c;
	logic signed [17:0] s_c;
	always_comb begin
		t_c = 37'(ss_q2) + 37'(ccc_q2);
		tr_c = (t_c + 37'(32768)) >>> 16;
		if (tr_c > 37'(65536)) s_c = 18'sd65536;
		else if (tr_c < -37'(65536)) s_c = -18'sd65536;
		else s_c = tr_c[17:0];
	end

	logic signed [17:0] s_q3;
	always_ff @(posedge clk) s_q3 <= s_c;

	logic signed [35:0] sq_q4;
	logic signed [17:0] s_q4;
	always_ff @(posedge clk) begin
		sq_q4 <= 36'(s_q3) * 36'(s_q3);
		s_q4 <= s_q3;
	end

	logic [17:0] root;
	logic signed [17:0] s_sq;
	sapp_sqrt u_sqrt (.clk(clk), .v(SQW'(36'sh1_0000_0000 - sq_q4)), .s_i(s_q4),
		.root(root), .s_o(s_sq));

	logic signed [ZW-1:0] z;
	sapp_atan2 #(.CORDIC_STEPS(CORDIC_STEPS)) u_atan (.clk(clk), .s(s_sq), .c(root), .z(z));

	logic signed [ZW-1:0] a_c;
	logic [14:0] a_q;
	always_comb begin
		a_c = (z + ZW'(1 << (SHB - 1))) >>> SHB;
		if (a_c > ZW'(90 * U)) a_c = ZW'(90 * U);
		if (a_c < -ZW'(90 * U)) a_c = -ZW'(90 * U);
	end

	logic [LAT3:0] vld_q;
	logic [LAT3:0] bad_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[LAT3-1:0], acc};
	end
	always_ff @(posedge clk) bad_q <= {bad_q[LAT3-1:0], bad_c};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= vld_q[LAT3];
	end
	always_ff @(posedge clk) a_q <= bad_q[LAT3] ? 15'd0 : a_c[14:0];
	assign altitude = a_q;
endmodule

// ===== design/sapp_checker.sv =====
module sapp_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic signed [14:0] altitude
);
	a_nobusy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (altitude <= 15'sd11520 && altitude >= -15'sd11520))
		else $error("altitude out of range");
	a_rst: assert property (@(posedge clk) !arst_n |=> !done)
		else $error("done after reset");
endmodule

bind solar_altitude_per_pixel_unit sapp_checker u_chk (.clk(clk), .arst_n(arst_n),
	.start(start), .busy(busy), .done(done), .altitude(altitude));
